FILE: rtl/ctcgd_pkg.sv
`timescale 1ns / 1ps

package ctcgd_pkg;

    localparam int CLASS_W     = 13;
    localparam int SCORE_W     = 8;
    localparam int OFFSET_W    = 14;
    localparam int SIZE_W      = 14;
    localparam int COUNT_W     = 9;
    localparam int SUM_W       = 16;
    localparam int MAX_CLASSES = 8192;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int S_DATA_W    = 8;
    localparam int S_USER_W    = 1;
    localparam int M_DATA_W    = 48;
    localparam int M_USER_W    = 2;

    localparam logic [SIZE_W-1:0] DICT_SIZE_RESET = SIZE_W'(97);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BLANK_CLASS = 2'd0,
        CFG_DICT_OFFSET = 2'd1,
        CFG_DICT_SIZE   = 2'd2
    } cfg_addr_t;

    // End of a time step, handed from the argmax stage to the emit stage
    typedef struct packed {
        logic               fire;
        logic               frame_last;
        logic [CLASS_W-1:0] arg_class;
        logic [SCORE_W-1:0] arg_score;
    } step_t;

    typedef struct packed {
        logic               char_valid;
        logic [CLASS_W-1:0] dict_index;
        logic               in_range;
        logic [SCORE_W-1:0] char_score;
        logic               frame_end;
        logic [COUNT_W-1:0] char_count;
        logic [SUM_W-1:0]   score_sum;
    } result_t;

endpackage

FILE: rtl/ctcgd_argmax.sv
`timescale 1ns / 1ps

module ctcgd_argmax (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic [ctcgd_pkg::SCORE_W-1:0]   class_score,
    input  logic                            step_last,
    input  logic                            frame_last,
    input  logic                            advance,
    output logic                            held,
    output ctcgd_pkg::step_t                step
);
    import ctcgd_pkg::*;

    logic               valid_reg, valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic               step_last_reg;
    logic               frame_last_reg;

    logic [CLASS_W-1:0] pos_reg, pos_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_class_reg, best_class_next;

    logic               fire;
    logic               take;
    logic [SCORE_W-1:0] cand_score;
    logic [CLASS_W-1:0] cand_class;

    assign fire = valid_reg && advance;
    assign held = valid_reg;

    // First score of a step always takes over; later ones only when strictly greater
    always_comb begin
        take       = (pos_reg == '0) || (score_reg > best_score_reg);
        cand_score = take ? score_reg : best_score_reg;
        cand_class = take ? pos_reg : best_class_reg;
    end

    always_comb begin
        valid_next      = valid_reg;
        pos_next        = pos_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
        if (fire) begin
            if (step_last_reg) begin
                pos_next        = '0;
                best_score_next = '0;
                best_class_next = '0;
            end else begin
                best_score_next = cand_score;
                best_class_next = cand_class;
                if (pos_reg != CLASS_W'(MAX_CLASSES - 1)) begin
                    pos_next = pos_reg + CLASS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            pos_reg        <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
        end else begin
            valid_reg      <= valid_next;
            pos_reg        <= pos_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            score_reg      <= class_score;
            step_last_reg  <= step_last;
            frame_last_reg <= frame_last;
        end
    end

    always_comb begin
        step.fire       = fire && step_last_reg;
        step.frame_last = frame_last_reg;
        step.arg_class  = cand_class;
        step.arg_score  = cand_score;
    end

    a_step_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && step_last_reg) |=> (pos_reg == '0 && best_score_reg == '0))
        else $error("argmax not cleared after step end");

    a_pos_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !step_last_reg) |=> (pos_reg != '0))
        else $error("class position did not advance");

endmodule

FILE: rtl/ctcgd_emit.sv
`timescale 1ns / 1ps

module ctcgd_emit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ctcgd_pkg::step_t                step,
    input  logic [ctcgd_pkg::CLASS_W-1:0]   blank_class,
    input  logic [ctcgd_pkg::OFFSET_W-1:0]  dict_offset,
    input  logic [ctcgd_pkg::SIZE_W-1:0]    dict_size,
    input  logic                            m_tready,
    output logic                            m_valid,
    output ctcgd_pkg::result_t              result
);
    import ctcgd_pkg::*;

    localparam int DIFF_W = CLASS_W + 2;

    logic               prev_valid_reg, prev_valid_next;
    logic [CLASS_W-1:0] prev_class_reg, prev_class_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    result_t            res;

    logic               emit;
    logic               produce;
    logic [DIFF_W-1:0]  diff;
    logic               in_rng;
    logic [SCORE_W-1:0] sc_out;
    logic [SUM_W:0]     sum_wide;

    always_comb begin
        emit = !(prev_valid_reg && step.arg_class == prev_class_reg)
               && (step.arg_class != blank_class);
        // Signed index: class is nonnegative, offset sign-extends
        diff = {2'b00, step.arg_class}
               - {{(DIFF_W - OFFSET_W){dict_offset[OFFSET_W-1]}}, dict_offset};
        in_rng = !diff[DIFF_W-1]
                 && (diff[SIZE_W-1:0] < dict_size)
                 && (diff[SIZE_W-1:0] < SIZE_W'(MAX_CLASSES));
        sc_out   = (emit && in_rng) ? step.arg_score : '0;
        sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - SCORE_W){1'b0}}, sc_out};
        produce  = emit || step.frame_last;

        count_next      = count_reg;
        sum_next        = sum_reg;
        prev_valid_next = prev_valid_reg;
        prev_class_next = prev_class_reg;
        if (emit) begin
            if (count_reg != '1) begin
                count_next = count_reg + COUNT_W'(1);
            end
            sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end

        res.char_valid = emit;
        res.dict_index = (emit && in_rng) ? diff[CLASS_W-1:0] : '0;
        res.in_range   = emit && in_rng;
        res.char_score = sc_out;
        res.frame_end  = step.frame_last;
        res.char_count = count_next;
        res.score_sum  = sum_next;

        if (step.fire) begin
            if (step.frame_last) begin
                // Frame closed: drop totals and history
                count_next      = '0;
                sum_next        = '0;
                prev_valid_next = 1'b0;
                prev_class_next = '0;
            end else begin
                prev_valid_next = 1'b1;
                prev_class_next = step.arg_class;
            end
        end else begin
            count_next = count_reg;
            sum_next   = sum_reg;
        end

        out_valid_next = out_valid_reg;
        if (step.fire) begin
            out_valid_next = produce;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            prev_class_reg <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            prev_valid_reg <= prev_valid_next;
            prev_class_reg <= prev_class_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.fire && produce) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

    a_no_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.char_valid) |->
        (out_reg.dict_index == '0 && !out_reg.in_range && out_reg.char_score == '0))
        else $error("empty result carries character fields");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.in_range) |->
        (out_reg.dict_index == '0 && out_reg.char_score == '0))
        else $error("out-of-range result carries index or score");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.fire && step.frame_last) |=>
        (count_reg == '0 && sum_reg == '0 && !prev_valid_reg))
        else $error("frame totals not cleared after frame end");

    a_only_emit_or_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |->
        (out_reg.char_valid || out_reg.frame_end))
        else $error("result without character or frame end");

endmodule

FILE: rtl/ctc_greedy_decoder.sv
// CTC greedy decoder: running argmax per time step, repeat/blank removal, frame totals.
// Path: the step's last score is held in the input register, passes the argmax/emit logic
// and is taken into the result register, from which it is offered on m_*.
// Throughput: one class score per cycle; an input register and a result register
// bound the argmax/emit logic, so the stream only stalls when m_tready holds it off.
// Reset: aresetn is synchronous, active low; clears state, totals and registers
// (blank_class 0, dictionary_offset 0, dictionary_size 97).
`timescale 1ns / 1ps

module ctc_greedy_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Score stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ctcgd_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] class_score
    input  logic                                s_tlast,   // step_last
    input  logic [ctcgd_pkg::S_USER_W-1:0]      s_tuser,   // [0] frame_last
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ctcgd_pkg::M_DATA_W-1:0]      m_tdata,   // [12:0] dict_index,
                                                           // [20:13] char_score,
                                                           // [29:21] char_count,
                                                           // [45:30] score_sum,
                                                           // [47:46] zero
    output logic                                m_tlast,   // frame_end
    output logic [ctcgd_pkg::M_USER_W-1:0]      m_tuser,   // [0] char_valid, [1] in_range
    // Register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctcgd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ctcgd_pkg::*;

    logic [CLASS_W-1:0]  blank_class_reg;
    logic [OFFSET_W-1:0] dict_offset_reg;
    logic [SIZE_W-1:0]   dict_size_reg;

    logic    advance;
    logic    in_held;
    logic    s_accept;
    step_t   step;
    result_t result;

    // Registers are written any time; software must change them only while idle (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_class_reg <= '0;
            dict_offset_reg <= '0;
            dict_size_reg   <= DICT_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_BLANK_CLASS: blank_class_reg <= cfg_data[CLASS_W-1:0];
                CFG_DICT_OFFSET: dict_offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_DICT_SIZE:   dict_size_reg   <= cfg_data[SIZE_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // The held item moves on whenever the result register is empty or being drained
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_held || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input register plus running argmax of the current step
    ctcgd_argmax u_argmax (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (s_accept),
        .class_score (s_tdata[SCORE_W-1:0]),
        .step_last   (s_tlast),
        .frame_last  (s_tuser[0]),
        .advance     (advance),
        .held        (in_held),
        .step        (step)
    );

    // Repeat/blank removal, index mapping, frame totals and the result register
    ctcgd_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .blank_class (blank_class_reg),
        .dict_offset (dict_offset_reg),
        .dict_size   (dict_size_reg),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .result      (result)
    );

    // Pack the result item
    assign m_tdata = {2'b00, result.score_sum, result.char_count,
                      result.char_score, result.dict_index};
    assign m_tlast = result.frame_end;
    assign m_tuser = {result.in_range, result.char_valid};

endmodule
